/* rtl/vslerp_pkg.sv */
// ----------------------------------------------------------------------------
// vslerp_pkg
// Shared constants, arctangent table and transaction side-band types for the
// vector slerp pipeline.
// ----------------------------------------------------------------------------
package vslerp_pkg;

	localparam int FRAC_BITS        = 14;
	localparam int ANG_BITS         = 30;
	localparam int UP_SHIFT         = ANG_BITS - FRAC_BITS;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_W         = 34;
	localparam int ANGLE_W          = 32;
	localparam int VEC_W            = 16;
	localparam int FRAC_W           = 15;
	localparam int REL_W            = 19;
	localparam int LEN2_W           = 38;
	localparam int LEN_W            = (LEN2_W + 1) / 2;
	localparam int REM_W            = 2 * FRAC_BITS + 1;
	localparam int SQ_W             = (REM_W + 1) / 2;
	localparam int RECIP_SHIFT      = 46;
	localparam int RECIP_W          = RECIP_SHIFT + 1;
	localparam int RECIP_LO_W       = 24;
	localparam int DIR_SHIFT        = RECIP_SHIFT - ANG_BITS;
	localparam int DIR_W            = 32;

	localparam logic [CORDIC_W-1:0] PI_Q30       = 34'd3373259426;
	localparam logic [CORDIC_W-1:0] HALF_PI_Q30  = 34'd1686629713;
	localparam logic [CORDIC_W-1:0] GAIN_INV_Q30 = 34'd652032874;

	localparam logic [29:0] ATAN_TABLE [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,
		30'd64,        30'd32,        30'd16,        30'd8,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	typedef struct packed {
		logic [2:0][VEC_W-1:0] st;
		logic [2:0][REL_W-1:0] rel;
		logic [REM_W-1:0]      rem;
		logic [FRAC_W-1:0]     frac;
		logic [VEC_W-1:0]      dot;
		logic                  degen;
	} len_side_t;

	typedef struct packed {
		logic [2:0][VEC_W-1:0] st;
		logic [2:0][DIR_W-1:0] dir;
		logic [FRAC_W-1:0]     frac;
		logic [VEC_W-1:0]      dot;
		logic                  degen;
	} acos_side_t;

	typedef struct packed {
		logic [2:0][VEC_W-1:0] st;
		logic [2:0][DIR_W-1:0] dir;
		logic                  degen;
		logic                  swap;
	} rot_side_t;

	typedef struct packed {
		logic [2:0][VEC_W-1:0] res;
		logic                  degen;
	} result_t;

endpackage

/* rtl/vslerp_isqrt.sv */
// ----------------------------------------------------------------------------
// vslerp_isqrt
// Pipelined integer square root, one root bit per stage, with side-band.
// ----------------------------------------------------------------------------
module vslerp_isqrt #(
	parameter int W      = 38,
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_in,
	input  logic [W-1:0]           rad_in,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   vld_out,
	output logic [(W+1)/2-1:0]     root_out,
	output logic [SIDE_W-1:0]      side_out
);
	localparam int N  = (W + 1) / 2;
	localparam int RW = 2 * N + 1;

	logic              vld_s  [N+1];
	logic [RW-1:0]     rad_s  [N+1];
	logic [RW-1:0]     root_s [N+1];
	logic [SIDE_W-1:0] side_s [N+1];

	assign vld_s[0]  = vld_in;
	assign rad_s[0]  = RW'(rad_in);
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [RW-1:0] BITV = RW'(1) << (2 * (N - 1 - i));
		logic [RW-1:0] trial;
		logic          take;

		assign trial = root_s[i] + BITV;
		assign take  = rad_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= take ? rad_s[i] - trial : rad_s[i];
				root_s[i+1] <= take ? (root_s[i] >> 1) + BITV : root_s[i] >> 1;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_out  = vld_s[N];
	assign root_out = root_s[N][N-1:0];
	assign side_out = side_s[N];

endmodule

/* rtl/vslerp_cordic.sv */
// ----------------------------------------------------------------------------
// vslerp_cordic
// Pipelined CORDIC, one micro-rotation per stage; vectoring or rotation mode.
// ----------------------------------------------------------------------------
module vslerp_cordic #(
	parameter int STEPS  = vslerp_pkg::CORDIC_STEPS_DEF,
	parameter bit ROTATE = 1'b0,
	parameter int SIDE_W = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 vld_in,
	input  logic signed [vslerp_pkg::CORDIC_W-1:0] x_in,
	input  logic signed [vslerp_pkg::CORDIC_W-1:0] y_in,
	input  logic signed [vslerp_pkg::CORDIC_W-1:0] z_in,
	input  logic [SIDE_W-1:0]                    side_in,
	output logic                                 vld_out,
	output logic signed [vslerp_pkg::CORDIC_W-1:0] x_out,
	output logic signed [vslerp_pkg::CORDIC_W-1:0] y_out,
	output logic signed [vslerp_pkg::CORDIC_W-1:0] z_out,
	output logic [SIDE_W-1:0]                    side_out
);
	import vslerp_pkg::*;

	logic                       vld_s  [STEPS+1];
	logic signed [CORDIC_W-1:0] x_s    [STEPS+1];
	logic signed [CORDIC_W-1:0] y_s    [STEPS+1];
	logic signed [CORDIC_W-1:0] z_s    [STEPS+1];
	logic [SIDE_W-1:0]          side_s [STEPS+1];

	assign vld_s[0]  = vld_in;
	assign x_s[0]    = x_in;
	assign y_s[0]    = y_in;
	assign z_s[0]    = z_in;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] xs, ys, at;
		logic                       neg;

		assign xs  = x_s[i] >>> i;
		assign ys  = y_s[i] >>> i;
		assign at  = CORDIC_W'(ATAN_TABLE[i]);
		// rotate counter-clockwise when the residual angle or y says so
		assign neg = ROTATE ? !z_s[i][CORDIC_W-1] : y_s[i][CORDIC_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (neg) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + at;
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_out  = vld_s[STEPS];
	assign x_out    = x_s[STEPS];
	assign y_out    = y_s[STEPS];
	assign z_out    = z_s[STEPS];
	assign side_out = side_s[STEPS];

endmodule

/* rtl/vector_slerp.sv */
// ----------------------------------------------------------------------------
// vector_slerp
// Spherical linear interpolation of two unit 3-vectors in Q2.14, fully
// pipelined: dot product, square roots, reciprocal divider and two CORDICs.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid, in_stall | start_x/y/z, end_x/y/z, fraction
//  out     | out_valid,out_stall| result_x/y/z, degenerate
//
//  One transaction per clock while in_stall is low; the pipeline depth is set by
//  the 47-stage reciprocal divider, the two square roots and the CORDICs.
//  Reset clears every valid bit; the data registers are not reset.
//  A two-entry output (register plus skid) decouples out_stall: in_stall is
//  the registered skid-full flag, so input stalls only once the skid fills.
// ----------------------------------------------------------------------------
module vector_slerp #(
	parameter int CORDIC_STEPS = vslerp_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [vslerp_pkg::VEC_W-1:0] start_x,
	input  logic signed [vslerp_pkg::VEC_W-1:0] start_y,
	input  logic signed [vslerp_pkg::VEC_W-1:0] start_z,
	input  logic signed [vslerp_pkg::VEC_W-1:0] end_x,
	input  logic signed [vslerp_pkg::VEC_W-1:0] end_y,
	input  logic signed [vslerp_pkg::VEC_W-1:0] end_z,
	input  logic [vslerp_pkg::FRAC_W-1:0]       fraction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [vslerp_pkg::VEC_W-1:0] result_x,
	output logic signed [vslerp_pkg::VEC_W-1:0] result_y,
	output logic signed [vslerp_pkg::VEC_W-1:0] result_z,
	output logic        degenerate
);
	import vslerp_pkg::*;

	localparam logic [FRAC_W-1:0]      ONE_U  = FRAC_W'(2 ** FRAC_BITS);
	localparam logic signed [19:0]     ONE_S  = 20'(2 ** FRAC_BITS);
	localparam logic signed [33:0]     DHALF  = 34'(2 ** (FRAC_BITS - 1));
	localparam logic signed [31:0]     ONE_SQ = 32'(2 ** (2 * FRAC_BITS));
	localparam logic signed [49:0]     RHALF  = 50'(2 ** (ANG_BITS - 1));

	logic    adv;
	logic    skid_vld_q;
	result_t skid_q;
	result_t out_q;
	result_t res_c;

	assign adv      = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// ---- s1: products for the dot product
	logic signed [VEC_W-1:0] st_in [3];
	logic signed [VEC_W-1:0] en_in [3];
	assign st_in[0] = start_x;
	assign st_in[1] = start_y;
	assign st_in[2] = start_z;
	assign en_in[0] = end_x;
	assign en_in[1] = end_y;
	assign en_in[2] = end_z;

	logic                    vld_s1;
	logic signed [VEC_W-1:0] st_s1 [3];
	logic signed [VEC_W-1:0] en_s1 [3];
	logic signed [31:0]      sp_s1 [3];
	logic [FRAC_W-1:0]       frac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				st_s1[k] <= st_in[k];
				en_s1[k] <= en_in[k];
				sp_s1[k] <= st_in[k] * en_in[k];
			end
			frac_s1 <= (fraction > ONE_U) ? ONE_U : fraction;
		end
	end

	// ---- s2: rounded, clamped dot
	logic signed [33:0]      dsum;
	logic signed [19:0]      dsh;
	logic signed [VEC_W-1:0] dot_c;
	assign dsum = 34'(sp_s1[0]) + 34'(sp_s1[1]) + 34'(sp_s1[2]) + DHALF;
	assign dsh  = 20'(dsum >>> FRAC_BITS);

	always_comb begin
		priority if (dsh > ONE_S)
			dot_c = VEC_W'(ONE_S);
		else if (dsh < -ONE_S)
			dot_c = VEC_W'(-ONE_S);
		else
			dot_c = dsh[VEC_W-1:0];
	end

	logic                    vld_s2;
	logic signed [VEC_W-1:0] st_s2 [3];
	logic signed [VEC_W-1:0] en_s2 [3];
	logic [FRAC_W-1:0]       frac_s2;
	logic signed [VEC_W-1:0] dot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2   <= st_s1;
			en_s2   <= en_s1;
			frac_s2 <= frac_s1;
			dot_s2  <= dot_c;
		end
	end

	// ---- s3: start*dot and 1 - dot^2
	logic signed [31:0] dsq;
	assign dsq = dot_s2 * dot_s2;

	logic                    vld_s3;
	logic signed [VEC_W-1:0] st_s3 [3];
	logic signed [VEC_W-1:0] en_s3 [3];
	logic signed [31:0]      sd_s3 [3];
	logic [REM_W-1:0]        rem_s3;
	logic [FRAC_W-1:0]       frac_s3;
	logic signed [VEC_W-1:0] dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (adv)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				sd_s3[k] <= st_s2[k] * dot_s2;
			st_s3   <= st_s2;
			en_s3   <= en_s2;
			rem_s3  <= REM_W'(ONE_SQ - dsq);
			frac_s3 <= frac_s2;
			dot_s3  <= dot_s2;
		end
	end

	// ---- s4: unnormalised direction
	logic                    vld_s4;
	logic signed [VEC_W-1:0] st_s4 [3];
	logic signed [REL_W-1:0] rel_s4 [3];
	logic [REM_W-1:0]        rem_s4;
	logic [FRAC_W-1:0]       frac_s4;
	logic signed [VEC_W-1:0] dot_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (adv)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				rel_s4[k] <= REL_W'(32'(en_s3[k]) - (sd_s3[k] >>> FRAC_BITS));
			st_s4   <= st_s3;
			rem_s4  <= rem_s3;
			frac_s4 <= frac_s3;
			dot_s4  <= dot_s3;
		end
	end

	// ---- s5: squares
	logic signed [2*REL_W-1:0] relsq [3];
	for (genvar k = 0; k < 3; k++) begin : g_sq
		assign relsq[k] = rel_s4[k] * rel_s4[k];
	end

	logic                    vld_s5;
	logic signed [VEC_W-1:0] st_s5 [3];
	logic signed [REL_W-1:0] rel_s5 [3];
	logic [LEN2_W-2:0]       sq_s5 [3];
	logic [REM_W-1:0]        rem_s5;
	logic [FRAC_W-1:0]       frac_s5;
	logic signed [VEC_W-1:0] dot_s5;
	logic                    degen_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (adv)
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				sq_s5[k] <= relsq[k][LEN2_W-2:0];
			st_s5    <= st_s4;
			rel_s5   <= rel_s4;
			rem_s5   <= rem_s4;
			frac_s5  <= frac_s4;
			dot_s5   <= dot_s4;
			degen_s5 <= (rel_s4[0] == '0) && (rel_s4[1] == '0) && (rel_s4[2] == '0);
		end
	end

	// ---- s6: squared length
	logic                    vld_s6;
	logic [LEN2_W-1:0]       len2_s6;
	len_side_t               side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else if (adv)
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len2_s6 <= LEN2_W'(sq_s5[0]) + LEN2_W'(sq_s5[1]) + LEN2_W'(sq_s5[2]);
			for (int k = 0; k < 3; k++) begin
				side_s6.st[k]  <= st_s5[k];
				side_s6.rel[k] <= rel_s5[k];
			end
			side_s6.rem   <= rem_s5;
			side_s6.frac  <= frac_s5;
			side_s6.dot   <= dot_s5;
			side_s6.degen <= degen_s5;
		end
	end

	// ---- length
	logic             lq_vld;
	logic [LEN_W-1:0] lq_root;
	len_side_t        lq_side;

	vslerp_isqrt #(
		.W      (LEN2_W),
		.SIDE_W ($bits(len_side_t))
	) u_len_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s6),
		.rad_in   (len2_s6),
		.side_in  (side_s6),
		.vld_out  (lq_vld),
		.root_out (lq_root),
		.side_out (lq_side)
	);

	// ---- reciprocal 2^46 / length, one quotient bit per stage
	logic             dv_vld_s  [RECIP_W+1];
	logic [LEN_W:0]   dv_rem_s  [RECIP_W+1];
	logic [RECIP_W-1:0] dv_quo_s [RECIP_W+1];
	logic [LEN_W-1:0] dv_len_s  [RECIP_W+1];
	len_side_t        dv_side_s [RECIP_W+1];

	assign dv_vld_s[0]  = lq_vld;
	assign dv_rem_s[0]  = '0;
	assign dv_quo_s[0]  = '0;
	assign dv_len_s[0]  = lq_root;
	assign dv_side_s[0] = lq_side;

	for (genvar i = 0; i < RECIP_W; i++) begin : g_div
		logic [LEN_W:0] trial;
		logic           take;

		assign trial = {dv_rem_s[i][LEN_W-1:0], 1'(i == 0)};
		assign take  = trial >= {1'b0, dv_len_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[i+1] <= 1'b0;
			else if (adv)
				dv_vld_s[i+1] <= dv_vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[i+1]  <= take ? trial - {1'b0, dv_len_s[i]} : trial;
				dv_quo_s[i+1]  <= {dv_quo_s[i][RECIP_W-2:0], take};
				dv_len_s[i+1]  <= dv_len_s[i];
				dv_side_s[i+1] <= dv_side_s[i];
			end
		end
	end

	// ---- s7: partial products rel * recip
	logic [RECIP_W-1:0] recip;
	len_side_t          dvo;
	assign recip = dv_quo_s[RECIP_W];
	assign dvo   = dv_side_s[RECIP_W];

	logic                                 vld_s7;
	logic signed [REL_W+RECIP_LO_W:0]     pl_s7 [3];
	logic signed [REL_W+RECIP_W-RECIP_LO_W:0] ph_s7 [3];
	len_side_t                            side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else if (adv)
			vld_s7 <= dv_vld_s[RECIP_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pl_s7[k] <= $signed(dvo.rel[k]) *
					$signed({1'b0, recip[RECIP_LO_W-1:0]});
				ph_s7[k] <= $signed(dvo.rel[k]) *
					$signed({1'b0, recip[RECIP_W-1:RECIP_LO_W]});
			end
			side_s7 <= dvo;
		end
	end

	// ---- s8: unit direction, Q30
	logic signed [67:0] dfull [3];
	for (genvar k = 0; k < 3; k++) begin : g_dir
		assign dfull[k] = (68'(ph_s7[k]) <<< RECIP_LO_W) + 68'(pl_s7[k]);
	end

	logic             vld_s8;
	logic [REM_W-1:0] rem_s8;
	acos_side_t       side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s8 <= 1'b0;
		else if (adv)
			vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				side_s8.dir[k] <= dfull[k][DIR_W+DIR_SHIFT-1:DIR_SHIFT];
			side_s8.st    <= side_s7.st;
			side_s8.frac  <= side_s7.frac;
			side_s8.dot   <= side_s7.dot;
			side_s8.degen <= side_s7.degen;
			rem_s8        <= side_s7.rem;
		end
	end

	// ---- sqrt(1 - dot^2)
	logic            rq_vld;
	logic [SQ_W-1:0] rq_root;
	acos_side_t      rq_side;

	vslerp_isqrt #(
		.W      (REM_W),
		.SIDE_W ($bits(acos_side_t))
	) u_sin_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s8),
		.rad_in   (rem_s8),
		.side_in  (side_s8),
		.vld_out  (rq_vld),
		.root_out (rq_root),
		.side_out (rq_side)
	);

	// ---- acos by vectoring; quarter-turn pre-rotation for negative dot
	logic signed [CORDIC_W-1:0] vx, vy, vz, xd, yd;
	assign xd = CORDIC_W'($signed(rq_side.dot)) <<< UP_SHIFT;
	assign yd = CORDIC_W'(rq_root) << UP_SHIFT;

	always_comb begin
		if (rq_side.dot[VEC_W-1]) begin
			vx = yd;
			vy = -xd;
			vz = HALF_PI_Q30;
		end else begin
			vx = xd;
			vy = yd;
			vz = '0;
		end
	end

	logic                       vc_vld;
	logic signed [CORDIC_W-1:0] vc_z;
	acos_side_t                 vc_side;

	vslerp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.ROTATE (1'b0),
		.SIDE_W ($bits(acos_side_t))
	) u_acos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (rq_vld),
		.x_in     (vx),
		.y_in     (vy),
		.z_in     (vz),
		.side_in  (rq_side),
		.vld_out  (vc_vld),
		.x_out    (),
		.y_out    (),
		.z_out    (vc_z),
		.side_out (vc_side)
	);

	// ---- s9: clamp acos, scale by fraction
	logic [ANGLE_W-1:0]        acos_c;
	logic [ANGLE_W+FRAC_W-1:0] tprod;

	always_comb begin
		priority if (vc_z[CORDIC_W-1])
			acos_c = '0;
		else if (vc_z > $signed(PI_Q30))
			acos_c = PI_Q30[ANGLE_W-1:0];
		else
			acos_c = vc_z[ANGLE_W-1:0];
	end
	assign tprod = acos_c * vc_side.frac;

	logic               vld_s9;
	logic [ANGLE_W-1:0] theta_s9;
	acos_side_t         side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else if (adv)
			vld_s9 <= vc_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			theta_s9 <= tprod[ANGLE_W+FRAC_BITS-1:FRAC_BITS];
			side_s9  <= vc_side;
		end
	end

	// ---- cos/sin by rotation
	logic                       rot_swap;
	logic signed [CORDIC_W-1:0] rz;
	rot_side_t                  rin_side;

	assign rot_swap       = CORDIC_W'(theta_s9) > HALF_PI_Q30;
	assign rz             = rot_swap ? CORDIC_W'(theta_s9) - HALF_PI_Q30 : CORDIC_W'(theta_s9);
	assign rin_side.st    = side_s9.st;
	assign rin_side.dir   = side_s9.dir;
	assign rin_side.degen = side_s9.degen;
	assign rin_side.swap  = rot_swap;

	logic                       rc_vld;
	logic signed [CORDIC_W-1:0] rc_x, rc_y;
	rot_side_t                  rc_side;

	vslerp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.ROTATE (1'b1),
		.SIDE_W ($bits(rot_side_t))
	) u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s9),
		.x_in     ($signed(GAIN_INV_Q30)),
		.y_in     ('0),
		.z_in     (rz),
		.side_in  (rin_side),
		.vld_out  (rc_vld),
		.x_out    (rc_x),
		.y_out    (rc_y),
		.z_out    (),
		.side_out (rc_side)
	);

	// ---- s10: start*cos and dir*sin
	logic signed [CORDIC_W-1:0] cs_w, sn_w;
	logic signed [DIR_W-1:0]    cs_c, sn_c;
	assign cs_w = rc_side.swap ? -rc_y : rc_x;
	assign sn_w = rc_side.swap ? rc_x : rc_y;
	assign cs_c = cs_w[DIR_W-1:0];
	assign sn_c = sn_w[DIR_W-1:0];

	logic                    vld_s10;
	logic signed [47:0]      m1_s10 [3];
	logic signed [63:0]      m2_s10 [3];
	logic [2:0][VEC_W-1:0]   st_s10;
	logic                    degen_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s10 <= 1'b0;
		else if (adv)
			vld_s10 <= rc_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				m1_s10[k] <= $signed(rc_side.st[k]) * cs_c;
				m2_s10[k] <= $signed(rc_side.dir[k]) * sn_c;
			end
			st_s10    <= rc_side.st;
			degen_s10 <= rc_side.degen;
		end
	end

	// ---- sum, round, saturate
	for (genvar k = 0; k < 3; k++) begin : g_res
		logic signed [49:0] acc;
		logic signed [19:0] rnd;
		logic [VEC_W-1:0]   sat;

		assign acc = 50'(m1_s10[k]) + 50'(m2_s10[k] >>> UP_SHIFT) + RHALF;
		assign rnd = 20'(acc >>> ANG_BITS);

		always_comb begin
			priority if (rnd > 20'sd32767)
				sat = 16'h7fff;
			else if (rnd < -20'sd32768)
				sat = 16'h8000;
			else
				sat = rnd[VEC_W-1:0];
		end

		assign res_c.res[k] = degen_s10 ? st_s10[k] : sat;
	end
	assign res_c.degen = degen_s10;

	// ---- output register and skid
	logic out_rdy;
	assign out_rdy = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid  <= skid_vld_q || vld_s10;
			skid_vld_q <= 1'b0;
		end else if (vld_s10 && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy)
			out_q <= skid_vld_q ? skid_q : res_c;
		else if (!skid_vld_q)
			skid_q <= res_c;
	end

	assign result_x   = out_q.res[0];
	assign result_y   = out_q.res[1];
	assign result_z   = out_q.res[2];
	assign degenerate = out_q.degen;

endmodule

/* rtl/vslerp_checker.sv */
// ----------------------------------------------------------------------------
// vslerp_checker
// Port-level checks on the output channel and the skid-driven input stall.
// ----------------------------------------------------------------------------
module vslerp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [vslerp_pkg::VEC_W-1:0] result_x,
	input logic signed [vslerp_pkg::VEC_W-1:0] result_y,
	input logic signed [vslerp_pkg::VEC_W-1:0] result_z,
	input logic degenerate
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_x) && $stable(result_y) &&
			$stable(result_z) && $stable(degenerate))
		else $error("output payload changed while stalled");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	a_skid_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid full while output register empty");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("skid not drained after output taken");

endmodule

bind vector_slerp vslerp_checker u_vslerp_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks vector_slerp against a bit-exact predictor of its fixed-point slerp
// (dot, acos and cos/sin CORDICs, square roots, reciprocal). Directed vectors
// cover extremes, parallel and opposite inputs and fraction saturation;
// random unit and raw vectors follow, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_top;
	import vslerp_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int LATENCY = 92 + 2 * STEPS;
	localparam longint LIMIT = 400000;

	typedef struct {
		logic signed [15:0] x, y, z;
		logic               degen;
	} slerp_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] start_x = 0, start_y = 0, start_z = 0;
	logic signed [15:0] end_x = 0, end_y = 0, end_z = 0;
	logic [14:0] fraction = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] result_x, result_y, result_z;
	logic degenerate;

	slerp_res_t expected_q[$];
	int errors = 0;
	longint cycle = 0;
	bit hold_off = 0;
	bit rx_quiet = 0;

	vector_slerp dut (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("vector_slerp: mismatch");
			$finish;
		end
	end

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint arctan(int i);
		return (i < 32) ? longint'(ATAN_TABLE[i]) : 0;
	endfunction

	function automatic longint acos_q30(longint dot);
		longint one = 1 << FRAC_BITS;
		longint x, y, z = 0, xs, ys, t;
		x = dot <<< UP_SHIFT;
		y = int_sqrt(one * one - dot * dot) <<< UP_SHIFT;
		if (x < 0) begin
			t = x; x = y; y = -t;
			z = longint'(HALF_PI_Q30);
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = floor_shr(x, i % 32); ys = floor_shr(y, i % 32);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += arctan(i % 32);
			end else begin
				x = x - ys; y = y + xs; z -= arctan(i % 32);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
		return z;
	endfunction

	function automatic slerp_res_t predict_slerp(logic signed [15:0] s[3],
			logic signed [15:0] e[3], logic [14:0] fr);
		slerp_res_t r;
		longint one = 1 << FRAC_BITS;
		longint f, dot, rel[3], d[3], len2 = 0, len, recip, theta, z, x, y, xs, ys;
		longint cs, sn, acc, v;
		bit swap;
		f = fr > one ? one : fr;
		dot = floor_shr(longint'(s[0]) * longint'(e[0]) + longint'(s[1]) * longint'(e[1])
			+ longint'(s[2]) * longint'(e[2]) + (longint'(1) << (FRAC_BITS - 1)),
			FRAC_BITS);
		if (dot > one) dot = one;
		if (dot < -one) dot = -one;
		for (int k = 0; k < 3; k++) begin
			rel[k] = longint'(e[k]) - floor_shr(longint'(s[k]) * dot, FRAC_BITS);
			len2 += rel[k] * rel[k];
		end
		if (len2 == 0) begin
			r.x = s[0]; r.y = s[1]; r.z = s[2]; r.degen = 1;
			return r;
		end
		len = int_sqrt(len2);
		recip = (longint'(1) << 46) / len;
		for (int k = 0; k < 3; k++) d[k] = floor_shr(rel[k] * recip, 16);
		theta = (acos_q30(dot) * f) >> FRAC_BITS;
		swap = theta > longint'(HALF_PI_Q30);
		z = swap ? theta - longint'(HALF_PI_Q30) : theta;
		x = longint'(GAIN_INV_Q30); y = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = floor_shr(x, i % 32); ys = floor_shr(y, i % 32);
			if (z >= 0) begin
				x = x - ys; y = y + xs; z -= arctan(i % 32);
			end else begin
				x = x + ys; y = y - xs; z += arctan(i % 32);
			end
		end
		cs = swap ? -y : x;
		sn = swap ? x : y;
		for (int k = 0; k < 3; k++) begin
			acc = longint'(s[k]) * cs + floor_shr(d[k] * sn, ANG_BITS - FRAC_BITS);
			v = floor_shr(acc + (longint'(1) << (ANG_BITS - 1)), ANG_BITS);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			if (k == 0) r.x = 16'(v); else if (k == 1) r.y = 16'(v); else r.z = 16'(v);
		end
		r.degen = 0;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("[%0d] %s: got %0d, expected %0d", cycle, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		slerp_res_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report("unexpected transaction", 1, 0);
			end else begin
				w = expected_q.pop_front();
				if (result_x !== w.x) report("result_x", result_x, w.x);
				if (result_y !== w.y) report("result_y", result_y, w.y);
				if (result_z !== w.z) report("result_z", result_z, w.z);
				if (degenerate !== w.degen) report("degenerate", degenerate, w.degen);
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else if (rx_quiet) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	int burst_left = 0;
	bit sender_quiet = 0;

	// valid drops only while waiting between bursts
	task automatic send_item(logic signed [15:0] s[3], logic signed [15:0] e[3],
			logic [14:0] fr);
		while (!sender_quiet && burst_left == 0) begin
			in_valid <= 0;
			@(posedge clk);
			if ($urandom_range(0, 2) == 0) burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1;
		start_x <= s[0]; start_y <= s[1]; start_z <= s[2];
		end_x <= e[0]; end_y <= e[1]; end_z <= e[2];
		fraction <= fr;
		expected_q.push_back(predict_slerp(s, e, fr));
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) burst_left--;
	endtask

	task automatic rand_unit(output logic signed [15:0] v[3]);
		real a, b, n;
		a = $urandom_range(0, 62831) / 10000.0;
		b = ($urandom_range(0, 20000) / 10000.0) - 1.0;
		n = $sqrt(1.0 - b * b);
		v[0] = 16'($rtoi(16384.0 * n * $cos(a)));
		v[1] = 16'($rtoi(16384.0 * n * $sin(a)));
		v[2] = 16'($rtoi(16384.0 * b));
		for (int k = 0; k < 3; k++)
			if ($urandom_range(0, 3) == 0)
				v[k] = v[k] + 16'($signed($urandom_range(0, 6)) - 3);
	endtask

	task automatic test_directed();
		logic signed [15:0] s[3], e[3];
		s = '{16384, 0, 0}; e = '{0, 16384, 0};
		send_item(s, e, 0); send_item(s, e, 16384); send_item(s, e, 8192);
		send_item(s, e, 15'h7fff); send_item(s, e, 20000);
		e = '{16384, 0, 0}; send_item(s, e, 8192);              // parallel
		e = '{-16384, 0, 0}; send_item(s, e, 8192);             // opposite
		s = '{0, 0, 0}; e = '{0, 0, 0}; send_item(s, e, 5000);  // zero
		s = '{16384, 0, 0}; e = '{-11585, 11585, 0};             // obtuse
		send_item(s, e, 16384); send_item(s, e, 12000);
		s = '{-11585, 0, 11585}; e = '{0, -16384, 0}; send_item(s, e, 16383);
		s = '{32767, 32767, 32767}; e = '{-32768, -32768, -32768};
		send_item(s, e, 8192);
		s = '{-32768, -32768, -32768}; e = '{32767, -32768, 32767};
		send_item(s, e, 16384);
		s = '{32767, -32768, 0}; e = '{32767, 32767, -32768}; send_item(s, e, 1);
		s = '{1, -1, 0}; e = '{-1, 1, 1}; send_item(s, e, 16384);
		s = '{0, 0, 16384}; e = '{0, 0, 16384}; send_item(s, e, 16384);
	endtask

	task automatic test_random(int n);
		logic signed [15:0] s[3], e[3];
		logic [14:0] fr;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					for (int k = 0; k < 3; k++) begin
						s[k] = 16'($urandom); e[k] = 16'($urandom);
					end
				end
				2: begin
					rand_unit(s); e = s;
				end
				default: begin
					rand_unit(s); rand_unit(e);
				end
			endcase
			case ($urandom_range(0, 5))
				0: fr = 15'($urandom);
				1: fr = 16384;
				2: fr = 0;
				default: fr = 15'($urandom_range(0, 16384));
			endcase
			send_item(s, e, fr);
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (LATENCY + 100) @(posedge clk);
				hold_off = 0;
			end
			begin
				sender_quiet = 1;
				test_random(LATENCY + 60);
				sender_quiet = 0;
			end
		join
	endtask

	task automatic test_full_rate();
		rx_quiet = 1;
		sender_quiet = 1;
		test_random(150);
		sender_quiet = 0;
		rx_quiet = 0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_backpressure();
		test_full_rate();
		test_random(100);
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("vector_slerp: match");
		else
			$display("vector_slerp: mismatch");
		$finish;
	end
endmodule

/* files.f */
rtl/vslerp_pkg.sv
rtl/vslerp_isqrt.sv
rtl/vslerp_cordic.sv
rtl/vector_slerp.sv
rtl/vslerp_checker.sv
tb/tb_top.sv
